@@ sv/wsds_pkg.sv @@
// ----------------------------------------------------------------------------
// wsds_pkg - shared definitions for the weighted-sum decision scorer
// Widths, capacity constants, register indexes and the control structs that
// pass between the controller and its serial arithmetic units.
// ----------------------------------------------------------------------------
package wsds_pkg;

    // Capacity
    localparam int MAX_ALT     = 64;
    localparam int MAX_CRIT    = 16;
    localparam int ROWS_CAP    = MAX_ALT + 1;
    localparam int STORE_DEPTH = ROWS_CAP * MAX_CRIT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH + 1);
    localparam int ALT_W       = $clog2(ROWS_CAP + 1);
    localparam int COL_W       = $clog2(MAX_CRIT);

    // Field widths
    localparam int VALUE_W = 16;
    localparam int CRIT_W  = 5;
    localparam int MASK_W  = 16;
    localparam int SCORE_W = 25;

    // Arithmetic
    localparam int RATIO_W    = VALUE_W + 1;
    localparam int DIV_W      = 2 * VALUE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int MAC_CNT_W  = $clog2(VALUE_W);
    localparam int SUM_W      = 37;
    localparam int FRAC_SHIFT = 12;
    localparam logic [RATIO_W-1:0] ONE_Q16 = RATIO_W'(65536);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CRITERIA = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MASK     = CFG_IDX_W'(1);

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef struct packed {
        logic start;
        logic clear;
    } mac_cmd_t;

endpackage

@@ sv/wsds_item_if.sv @@
// ----------------------------------------------------------------------------
// wsds_item_if - input item channel
// Carries one matrix element or weight per transfer, plus the end-of-load flag.
// ----------------------------------------------------------------------------
interface wsds_item_if;
    logic                            valid;
    logic                            ready;
    logic [wsds_pkg::VALUE_W-1:0]    value;
    logic                            last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

@@ sv/wsds_result_if.sv @@
// ----------------------------------------------------------------------------
// wsds_result_if - result channel
// Carries one alternative score per transfer with its last and overflow flags.
// ----------------------------------------------------------------------------
interface wsds_result_if;
    logic                            valid;
    logic                            ready;
    logic [wsds_pkg::SCORE_W-1:0]    score;
    logic                            score_last;
    logic                            overflow;

    modport source (output valid, output score, output score_last, output overflow,
                    input ready);
    modport sink   (input valid, input score, input score_last, input overflow,
                    output ready);
endinterface

@@ sv/wsds_cfg_if.sv @@
// ----------------------------------------------------------------------------
// wsds_cfg_if - configuration write channel
// Carries a register index and write data per transfer.
// ----------------------------------------------------------------------------
interface wsds_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [wsds_pkg::CFG_IDX_W-1:0]     index;
    logic [wsds_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/wsds_div.sv @@
// ----------------------------------------------------------------------------
// wsds_div - radix-2 serial divider
// Restoring division of a 32-bit dividend by a 16-bit divisor, one quotient
// bit per cycle, MSB first. Quotient holds after the done pulse.
// ----------------------------------------------------------------------------
module wsds_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [wsds_pkg::DIV_W-1:0]      dividend,
    input  logic [wsds_pkg::VALUE_W-1:0]    divisor,
    output logic [wsds_pkg::DIV_W-1:0]      quotient,
    output wsds_pkg::unit_stat_t            stat
);

    logic [wsds_pkg::VALUE_W-1:0]   rem_reg, rem_next;
    logic [wsds_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [wsds_pkg::VALUE_W-1:0]   dsr_reg, dsr_next;
    logic [wsds_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [wsds_pkg::VALUE_W:0]     trial;
    logic                           fits;

    assign trial = {rem_reg, quo_reg[wsds_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, subtract when the divisor fits
            rem_next = fits ? wsds_pkg::VALUE_W'(trial - {1'b0, dsr_reg})
                            : trial[wsds_pkg::VALUE_W-1:0];
            quo_next = {quo_reg[wsds_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + wsds_pkg::DIV_CNT_W'(1);
            if (cnt_reg == wsds_pkg::DIV_CNT_W'(wsds_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ sv/wsds_mac.sv @@
// ----------------------------------------------------------------------------
// wsds_mac - bit-serial multiply-accumulate
// Adds ratio * weight into a running sum, one weight bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module wsds_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wsds_pkg::mac_cmd_t              cmd,
    input  logic [wsds_pkg::RATIO_W-1:0]    mcand,
    input  logic [wsds_pkg::VALUE_W-1:0]    mplier,
    output logic [wsds_pkg::SUM_W-1:0]      sum,
    output wsds_pkg::unit_stat_t            stat
);

    localparam int SH_W = wsds_pkg::RATIO_W + wsds_pkg::VALUE_W;

    logic [wsds_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [SH_W-1:0]                mc_reg, mc_next;
    logic [wsds_pkg::VALUE_W-1:0]   mp_reg, mp_next;
    logic [wsds_pkg::MAC_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    always_comb
    begin
        sum_next  = sum_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.clear)
        begin
            sum_next = '0;
        end
        if (cmd.start)
        begin
            mc_next   = SH_W'(mcand);
            mp_next   = mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                sum_next = sum_reg + wsds_pkg::SUM_W'(mc_reg);
            end
            mc_next  = {mc_reg[SH_W-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[wsds_pkg::VALUE_W-1:1]};
            cnt_next = cnt_reg + wsds_pkg::MAC_CNT_W'(1);
            if (cnt_reg == wsds_pkg::MAC_CNT_W'(wsds_pkg::VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign sum       = sum_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ sv/weighted_sum_decision_scoring.sv @@
// ----------------------------------------------------------------------------
// weighted_sum_decision_scoring - simple additive weighting scorer
// Loads a decision matrix and weight row, normalizes columns by their maxima
// and emits one weighted score per alternative.
// ----------------------------------------------------------------------------
// Loading takes one matrix element per cycle into a 1040-entry store. The item
// with last set ends the load; the row count is then found by the serial
// divider and the column maxima by a scan of the stored alternatives, which
// reads and then compares each element in turn. The first score follows without a
// further input; each later score is started by one accepted input item whose
// payload is ignored. Per column a score takes two store reads, a radix-2
// division for the ratio and a bit-serial multiply-accumulate for the weight;
// a column whose maximum is zero skips both. A finished score waits in the
// output register while the next item is taken.
// ----------------------------------------------------------------------------
module weighted_sum_decision_scoring (
    input  logic                   clk,
    input  logic                   rst_n,
    wsds_item_if.sink              item,
    wsds_result_if.source          result,
    wsds_cfg_if.sink               cfg
);

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_ROWS     = 4'd1;
    localparam logic [3:0] ST_MAX_RD   = 4'd2;
    localparam logic [3:0] ST_MAX_CMP  = 4'd3;
    localparam logic [3:0] ST_SC_RDX   = 4'd4;
    localparam logic [3:0] ST_SC_RDW   = 4'd5;
    localparam logic [3:0] ST_SC_RATIO = 4'd6;
    localparam logic [3:0] ST_SC_DIV   = 4'd7;
    localparam logic [3:0] ST_SC_MAC   = 4'd8;
    localparam logic [3:0] ST_SC_OUT   = 4'd9;
    localparam logic [3:0] ST_WAIT     = 4'd10;

    localparam int AW = wsds_pkg::ADDR_W;
    localparam int VW = wsds_pkg::VALUE_W;

    logic [3:0]                     state_reg, state_next;
    logic [wsds_pkg::CRIT_W-1:0]    crit_reg, crit_next;
    logic [wsds_pkg::MASK_W-1:0]    mask_reg, mask_next;
    logic [AW-1:0]                  count_reg, count_next;
    logic                           drop_reg, drop_next;
    logic [wsds_pkg::CRIT_W-1:0]    lat_cols_reg, lat_cols_next;
    logic [wsds_pkg::MASK_W-1:0]    lat_mask_reg, lat_mask_next;
    logic                           lat_drop_reg, lat_drop_next;
    logic [wsds_pkg::ALT_W-1:0]     alt_total_reg, alt_total_next;
    logic [wsds_pkg::ALT_W-1:0]     next_alt_reg, next_alt_next;
    logic [wsds_pkg::ALT_W-1:0]     a_reg, a_next;
    logic [wsds_pkg::COL_W-1:0]     j_reg, j_next;
    logic [AW-1:0]                  addr_reg, addr_next;
    logic [AW-1:0]                  base_reg, base_next;
    logic [AW-1:0]                  wbase_reg, wbase_next;
    logic [VW-1:0]                  maxv_reg, maxv_next;
    logic [VW-1:0]                  x_reg, x_next;
    logic [VW-1:0]                  w_reg, w_next;
    logic                           out_valid_reg, out_valid_next;
    logic [wsds_pkg::SCORE_W-1:0]   out_score_reg;
    logic                           out_last_reg;
    logic                           out_ovf_reg;

    // matrix store and column maxima
    logic [VW-1:0]                  mem [wsds_pkg::STORE_DEPTH];
    logic [VW-1:0]                  rd_data_reg;
    logic [AW-1:0]                  rd_addr;
    logic                           mem_we;
    logic [VW-1:0]                  colmax [wsds_pkg::MAX_CRIT];
    logic                           colmax_we;
    logic [VW-1:0]                  colmax_wdata;

    logic [wsds_pkg::CRIT_W-1:0]    eff_cols;
    logic [AW-1:0]                  cap;
    logic                           store_ok;
    logic [AW-1:0]                  cnt_after;
    logic                           item_fire;
    logic                           out_free;
    logic                           out_load;
    logic                           last_col;
    logic                           last_alt_scan;
    logic [VW-1:0]                  cmp_max;
    logic [AW-1:0]                  rows_q;
    logic [wsds_pkg::ALT_W-1:0]     rows;
    logic [wsds_pkg::ALT_W-1:0]     alt_new;
    logic [VW-1:0]                  col_m;

    logic                           div_start;
    logic [wsds_pkg::DIV_W-1:0]     div_dividend;
    logic [VW-1:0]                  div_divisor;
    logic [wsds_pkg::DIV_W-1:0]     div_quo;
    wsds_pkg::unit_stat_t           div_stat;
    logic [wsds_pkg::RATIO_W-1:0]   ratio;

    wsds_pkg::mac_cmd_t             mac_cmd;
    logic [wsds_pkg::SUM_W-1:0]     mac_sum;
    wsds_pkg::unit_stat_t           mac_stat;

    wsds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    wsds_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mac_cmd),
        .mcand  (ratio),
        .mplier (w_reg),
        .sum    (mac_sum),
        .stat   (mac_stat)
    );

    // clamp the row length into 1..MAX_CRIT
    always_comb
    begin
        if (crit_reg == '0)
        begin
            eff_cols = wsds_pkg::CRIT_W'(1);
        end
        else if (crit_reg > wsds_pkg::CRIT_W'(wsds_pkg::MAX_CRIT))
        begin
            eff_cols = wsds_pkg::CRIT_W'(wsds_pkg::MAX_CRIT);
        end
        else
        begin
            eff_cols = crit_reg;
        end
    end

    assign cap       = AW'(wsds_pkg::ROWS_CAP) * AW'(eff_cols);
    assign store_ok  = count_reg < cap;
    assign cnt_after = count_reg + AW'(store_ok);
    assign item_fire = item.valid && item.ready;
    assign item.ready = (state_reg == ST_LOAD) || (state_reg == ST_WAIT);
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || result.ready;

    assign last_col      = j_reg == wsds_pkg::COL_W'(lat_cols_reg - wsds_pkg::CRIT_W'(1));
    assign last_alt_scan = a_reg == (alt_total_reg - wsds_pkg::ALT_W'(1));
    assign cmp_max       = (rd_data_reg > maxv_reg) ? rd_data_reg : maxv_reg;
    assign col_m         = colmax[j_reg];

    assign rows_q  = div_quo[AW-1:0];
    assign rows    = (rows_q > AW'(wsds_pkg::ROWS_CAP)) ? wsds_pkg::ALT_W'(wsds_pkg::ROWS_CAP)
                                                        : rows_q[wsds_pkg::ALT_W-1:0];
    assign alt_new = rows - wsds_pkg::ALT_W'(1);

    // cost columns take one minus the ratio
    assign ratio = lat_mask_reg[j_reg] ? div_quo[wsds_pkg::RATIO_W-1:0]
                                       : wsds_pkg::ONE_Q16 - div_quo[wsds_pkg::RATIO_W-1:0];

    assign div_dividend = (state_reg == ST_LOAD) ? wsds_pkg::DIV_W'(cnt_after)
                                                 : {x_reg, {VW{1'b0}}};
    assign div_divisor  = (state_reg == ST_LOAD) ? VW'(eff_cols) : col_m;
    assign mem_we       = (state_reg == ST_LOAD) && item_fire && store_ok;

    always_comb
    begin
        state_next     = state_reg;
        crit_next      = crit_reg;
        mask_next      = mask_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        lat_cols_next  = lat_cols_reg;
        lat_mask_next  = lat_mask_reg;
        lat_drop_next  = lat_drop_reg;
        alt_total_next = alt_total_reg;
        next_alt_next  = next_alt_reg;
        a_next         = a_reg;
        j_next         = j_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        wbase_next     = wbase_reg;
        maxv_next      = maxv_reg;
        x_next         = x_reg;
        w_next         = w_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        rd_addr        = addr_reg;
        colmax_we      = 1'b0;
        colmax_wdata   = cmp_max;
        div_start      = 1'b0;
        mac_cmd.start  = 1'b0;
        mac_cmd.clear  = 1'b0;

        if (cfg.valid)
        begin
            case (cfg.index)
                wsds_pkg::REG_CRITERIA: crit_next = cfg.data[wsds_pkg::CRIT_W-1:0];
                wsds_pkg::REG_MASK:     mask_next = cfg.data;
                default:                ;
            endcase
        end

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (item_fire)
                begin
                    count_next = cnt_after;
                    if (!store_ok)
                    begin
                        drop_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        lat_cols_next = eff_cols;
                        lat_mask_next = mask_reg;
                        lat_drop_next = drop_reg || !store_ok;
                        count_next    = '0;
                        drop_next     = 1'b0;
                        div_start     = 1'b1;
                        state_next    = ST_ROWS;
                    end
                end
            end
            ST_ROWS:
            begin
                if (div_stat.done)
                begin
                    if (rows < wsds_pkg::ALT_W'(2))
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        alt_total_next = alt_new;
                        wbase_next     = AW'(alt_new) * AW'(lat_cols_reg);
                        a_next         = '0;
                        j_next         = '0;
                        addr_next      = '0;
                        maxv_next      = '0;
                        state_next     = ST_MAX_RD;
                    end
                end
            end
            ST_MAX_RD:
            begin
                state_next = ST_MAX_CMP;
            end
            ST_MAX_CMP:
            begin
                maxv_next = cmp_max;
                if (last_alt_scan)
                begin
                    // column done: store its maximum, move to the next column
                    colmax_we = 1'b1;
                    maxv_next = '0;
                    a_next    = '0;
                    if (last_col)
                    begin
                        j_next        = '0;
                        next_alt_next = '0;
                        base_next     = '0;
                        mac_cmd.clear = 1'b1;
                        state_next    = ST_SC_RDX;
                    end
                    else
                    begin
                        j_next     = j_reg + wsds_pkg::COL_W'(1);
                        addr_next  = AW'(j_reg) + AW'(1);
                        state_next = ST_MAX_RD;
                    end
                end
                else
                begin
                    a_next     = a_reg + wsds_pkg::ALT_W'(1);
                    addr_next  = addr_reg + AW'(lat_cols_reg);
                    state_next = ST_MAX_RD;
                end
            end
            ST_SC_RDX:
            begin
                rd_addr    = base_reg + AW'(j_reg);
                state_next = ST_SC_RDW;
            end
            ST_SC_RDW:
            begin
                x_next     = rd_data_reg;
                rd_addr    = wbase_reg + AW'(j_reg);
                state_next = ST_SC_RATIO;
            end
            ST_SC_RATIO:
            begin
                w_next = rd_data_reg;
                if (col_m != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_SC_DIV;
                end
                else if (last_col)
                begin
                    // zero maximum: the column adds nothing
                    state_next = ST_SC_OUT;
                end
                else
                begin
                    j_next     = j_reg + wsds_pkg::COL_W'(1);
                    state_next = ST_SC_RDX;
                end
            end
            ST_SC_DIV:
            begin
                if (div_stat.done)
                begin
                    mac_cmd.start = 1'b1;
                    state_next    = ST_SC_MAC;
                end
            end
            ST_SC_MAC:
            begin
                if (mac_stat.done)
                begin
                    if (last_col)
                    begin
                        state_next = ST_SC_OUT;
                    end
                    else
                    begin
                        j_next     = j_reg + wsds_pkg::COL_W'(1);
                        state_next = ST_SC_RDX;
                    end
                end
            end
            ST_SC_OUT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    next_alt_next  = next_alt_reg + wsds_pkg::ALT_W'(1);
                    base_next      = base_reg + AW'(lat_cols_reg);
                    if ((next_alt_reg + wsds_pkg::ALT_W'(1)) == alt_total_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                // each transfer here triggers the next score; drop its payload
                if (item_fire)
                begin
                    j_next        = '0;
                    mac_cmd.clear = 1'b1;
                    state_next    = ST_SC_RDX;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            crit_reg      <= wsds_pkg::CRIT_W'(1);
            mask_reg      <= '1;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            alt_total_reg <= '0;
            next_alt_reg  <= '0;
            a_reg         <= '0;
            j_reg         <= '0;
            lat_cols_reg  <= '0;
            lat_mask_reg  <= '0;
            lat_drop_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            crit_reg      <= crit_next;
            mask_reg      <= mask_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            alt_total_reg <= alt_total_next;
            next_alt_reg  <= next_alt_next;
            a_reg         <= a_next;
            j_reg         <= j_next;
            lat_cols_reg  <= lat_cols_next;
            lat_mask_reg  <= lat_mask_next;
            lat_drop_reg  <= lat_drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        base_reg  <= base_next;
        wbase_reg <= wbase_next;
        maxv_reg  <= maxv_next;
        x_reg     <= x_next;
        w_reg     <= w_next;
        if (out_load)
        begin
            out_score_reg <= mac_sum[wsds_pkg::FRAC_SHIFT +: wsds_pkg::SCORE_W];
            out_last_reg  <= (next_alt_reg + wsds_pkg::ALT_W'(1)) == alt_total_reg;
            out_ovf_reg   <= lat_drop_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg] <= item.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (colmax_we)
        begin
            colmax[j_reg] <= colmax_wdata;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.score      = out_score_reg;
    assign result.score_last = out_last_reg;
    assign result.overflow   = out_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= AW'(wsds_pkg::STORE_DEPTH))
        else $error("item count beyond store depth");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SC_RDX || state_reg == ST_SC_DIV || state_reg == ST_SC_MAC)
        |-> (wsds_pkg::CRIT_W'(j_reg) < lat_cols_reg))
        else $error("column index beyond latched row length");

    a_alt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SC_OUT || state_reg == ST_WAIT) |-> (next_alt_reg < alt_total_reg))
        else $error("alternative index beyond alternative count");

    a_ratio_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SC_DIV && div_stat.done)
        |-> (div_quo[wsds_pkg::DIV_W-1:wsds_pkg::RATIO_W] == '0))
        else $error("normalized ratio exceeds one");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!result.valid || result.ready))
        else $error("score loaded over an untaken result");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for weighted_sum_decision_scoring
// Streams decision matrices and weight rows into the scorer, tracks the
// load, normalization and weighted sums in a local model, and checks every
// score transfer against it under random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb;
    import wsds_pkg::*;

    localparam int SETTLE_CYCLES  = 3200;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int MAX_REPORTS    = 10;
    localparam int LOAD_TARGET    = 115;
    localparam int DRAW           = -1;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               last;
        logic               overflow;
    } score_rec_t;

    logic clk;
    logic rst_n;

    wsds_item_if   item_ch();
    wsds_result_if score_ch();
    wsds_cfg_if    cfg_ch();

    weighted_sum_decision_scoring u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (score_ch),
        .cfg    (cfg_ch)
    );

    // Scorer model state
    logic [CRIT_W-1:0]  crit_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [VALUE_W-1:0] mat [STORE_DEPTH];
    logic [VALUE_W-1:0] col_max [MAX_CRIT];
    int unsigned        fill;
    bit                 dropped;
    bit                 scoring;
    int unsigned        next_alt;
    int unsigned        alt_total;
    int unsigned        lat_cols;
    logic [MASK_W-1:0]  lat_mask;
    bit                 lat_drop;

    score_rec_t expected_scores[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int mismatches;
    int scores_checked;
    int load_items;
    int filler_items;
    int loads_closed;
    int overflow_loads;
    int reg_writes;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    function automatic int unsigned active_cols();
        int unsigned c;
        c = crit_reg;
        if (c == 0)
            c = 1;
        if (c > MAX_CRIT)
            c = MAX_CRIT;
        return c;
    endfunction

    function automatic logic [SCORE_W-1:0] alt_score(input int unsigned alt);
        logic [47:0]        acc;
        logic [31:0]        ratio;
        logic [VALUE_W-1:0] x;
        logic [VALUE_W-1:0] m;
        logic [VALUE_W-1:0] w;
        int unsigned        j;
        acc = '0;
        for (j = 0; j < lat_cols; j++)
        begin
            x = mat[alt * lat_cols + j];
            m = col_max[j];
            w = mat[alt_total * lat_cols + j];
            ratio = '0;
            if (m != 0)
            begin
                ratio = {x, 16'h0000} / m;
                // cost column: invert the ratio
                if (!lat_mask[j])
                    ratio = 32'h0001_0000 - ratio;
            end
            acc += ratio * w;
        end
        return acc[FRAC_SHIFT +: SCORE_W];
    endfunction

    function automatic void emit_score();
        score_rec_t rec;
        rec.score    = alt_score(next_alt);
        rec.last     = (next_alt + 1 == alt_total);
        rec.overflow = lat_drop;
        expected_scores.push_back(rec);
        next_alt++;
        if (next_alt >= alt_total)
            scoring = 1'b0;
    endfunction

    function automatic void absorb_item(input logic [VALUE_W-1:0] v, input logic l);
        int unsigned        c;
        int unsigned        rows;
        int unsigned        a;
        int unsigned        j;
        logic [VALUE_W-1:0] m;
        if (scoring)
        begin
            emit_score();
            return;
        end
        c = active_cols();
        if (fill < ROWS_CAP * c && fill < STORE_DEPTH)
        begin
            mat[fill] = v;
            fill++;
        end
        else
            dropped = 1'b1;
        if (!l)
            return;
        loads_closed++;
        rows = fill / c;
        if (rows > ROWS_CAP)
            rows = ROWS_CAP;
        lat_cols = c;
        lat_mask = mask_reg;
        lat_drop = dropped;
        fill     = 0;
        dropped  = 1'b0;
        if (rows < 2)
            return;
        if (lat_drop)
            overflow_loads++;
        alt_total = rows - 1;
        for (j = 0; j < MAX_CRIT; j++)
            col_max[j] = '0;
        for (j = 0; j < c; j++)
        begin
            m = '0;
            for (a = 0; a < alt_total; a++)
                if (mat[a * c + j] > m)
                    m = mat[a * c + j];
            col_max[j] = m;
        end
        next_alt = 0;
        scoring  = 1'b1;
        emit_score();
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CRITERIA: crit_reg = data[CRIT_W-1:0];
            REG_MASK:     mask_reg = data[MASK_W-1:0];
            default:      ;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_W'($urandom_range(15));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic l);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.value <= v;
        item_ch.last  <= l;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        if (scoring)
            filler_items++;
        else
            load_items++;
        absorb_item(v, l);
    endtask

    // Send n random elements; close the load on the final one if asked, and
    // scatter extra last flags with odds 1/noise_odds when noise_odds is set.
    task automatic send_run(input int unsigned n, input bit close,
                            input int unsigned noise_odds);
        int unsigned i;
        logic        l;
        for (i = 0; i < n; i++)
        begin
            l = close && (i == n - 1);
            if (noise_odds != 0 && $urandom_range(noise_odds - 1) == 0)
                l = 1'b1;
            send_item(rand_value(), l);
        end
    endtask

    // Feed ignored transfers until the last pending score has been started.
    task automatic flush_scores();
        while (scoring)
            send_item(rand_value(), 1'($urandom));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        apply_reg(idx, data);
        reg_writes++;
    endtask

    task automatic set_config(input int crit, input int mask);
        logic [CRIT_W-1:0] c;
        logic [MASK_W-1:0] mk;
        c  = (crit == DRAW) ? CRIT_W'($urandom_range(1, MAX_CRIT)) : CRIT_W'(crit);
        mk = (mask == DRAW) ? MASK_W'($urandom) : MASK_W'(mask);
        // upper data bits carry junk; only the low bits define the row length
        cfg_write(REG_CRITERIA, {11'($urandom), c});
        cfg_write(REG_MASK, mk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid, drain all scores, then give the core time to go idle.
    task automatic quiesce();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_scores.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_defaults_after_reset();
        // single row: too short to score
        send_item(16'h0001, 1'b1);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h1234, 1'b1);
        flush_scores();
    endtask

    task automatic test_cost_and_empty_columns();
        quiesce();
        cfg_write(REG_SPARE_A, CFG_DATA_W'($urandom));
        cfg_write(REG_SPARE_B, CFG_DATA_W'($urandom));
        set_config(3, 16'h0005);
        // column 0 all zero, column 1 cost, column 2 benefit
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b0);
        // partial trailing row is ignored
        send_item(16'hA5A5, 1'b0);
        send_item(16'h5A5A, 1'b1);
        flush_scores();
    endtask

    task automatic test_row_length_change();
        quiesce();
        set_config(2, 16'h0005);
        send_run(4, 1'b0, 0);
        quiesce();
        set_config(4, 16'h0005);
        send_run(4, 1'b1, 0);
        flush_scores();
    endtask

    task automatic test_row_cap();
        quiesce();
        set_config(2, DRAW);
        send_run(70, 1'b0, 0);
        quiesce();
        // shrink the row: stored count exceeds the new capacity
        set_config(1, DRAW);
        send_run(1, 1'b1, 0);
        flush_scores();
    endtask

    task automatic random_load();
        int unsigned c;
        int unsigned kind;
        int unsigned nalt;
        int unsigned n;
        c    = active_cols();
        kind = $urandom_range(99);
        if (kind < 4 && c <= 4)
            // overrun capacity; the closing transfer itself is dropped
            send_run(ROWS_CAP * c + $urandom_range(1, 5), 1'b1, 0);
        else if (kind < 12)
            send_run($urandom_range(1, 2 * c - 1), 1'b1, 0);
        else if (kind < 17)
            send_run($urandom_range(1, 3 * c), 1'b1, 8);
        else
        begin
            if (c <= 4 && $urandom_range(9) == 0)
                nalt = $urandom_range(7, MAX_ALT);
            else
                nalt = $urandom_range(1, 6);
            n = (nalt + 1) * c;
            if (c > 1 && $urandom_range(4) == 0)
                n += $urandom_range(1, c - 1);
            send_run(n, 1'b1, 0);
        end
        flush_scores();
    endtask

    task automatic test_random_traffic();
        int plan_crit [9] = '{1, 16, DRAW, 0, 31, DRAW, 17, DRAW, DRAW};
        int plan_mask [9] = '{DRAW, 'hFFFF, DRAW, 0, DRAW, DRAW, DRAW, 'hFFFF, DRAW};
        int send_pct  [3] = '{17, 80, 0};
        int recv_pct  [3] = '{80, 17, 0};
        int mode;
        int s;
        int target;
        for (mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = send_pct[mode];
            recv_idle_pct = recv_pct[mode];
            for (s = 0; s < 3; s++)
            begin
                quiesce();
                set_config(plan_crit[mode * 3 + s], plan_mask[mode * 3 + s]);
                target = load_items + LOAD_TARGET;
                while (load_items < target)
                    random_load();
            end
        end
    endtask

    task automatic test_output_stall();
        quiesce();
        set_config(2, DRAW);
        hold_request = 1'b1;
        send_run(25 * 2, 1'b1, 0);
        flush_scores();
    endtask

    // ------------------------------------------------------------------
    // Score sink: random idling plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        score_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                score_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            score_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endtask

    always @(posedge clk)
    begin : score_check
        score_rec_t want;
        if (rst_n && score_ch.valid === 1'b1 && score_ch.ready === 1'b1)
        begin
            if (expected_scores.size() == 0)
                note_mismatch($sformatf("unexpected score %0h last %0b overflow %0b",
                                        score_ch.score, score_ch.score_last,
                                        score_ch.overflow));
            else
            begin
                want = expected_scores.pop_front();
                scores_checked++;
                if (score_ch.score !== want.score || score_ch.score_last !== want.last
                    || score_ch.overflow !== want.overflow)
                    note_mismatch($sformatf(
                        "score exp %0h got %0h, last exp %0b got %0b, overflow exp %0b got %0b",
                        want.score, score_ch.score, want.last, score_ch.score_last,
                        want.overflow, score_ch.overflow));
            end
        end
    end

    // Abort when no channel has made a transfer for too long
    always @(posedge clk)
    begin
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
            || (score_ch.valid === 1'b1 && score_ch.ready === 1'b1)
            || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.value <= '0;
        item_ch.last  <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= '0;
        cfg_ch.data   <= '0;
        crit_reg       = CRIT_W'(1);
        mask_reg       = '1;
        fill           = 0;
        dropped        = 1'b0;
        scoring        = 1'b0;
        send_idle_pct  = 17;
        recv_idle_pct  = 80;
        hold_request   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_defaults_after_reset();
        test_cost_and_empty_columns();
        test_row_length_change();
        test_row_cap();
        test_random_traffic();
        test_output_stall();

        quiesce();
        $display("covered %0d loads (%0d over capacity), %0d load and %0d scoring transfers",
                 loads_closed, overflow_loads, load_items, filler_items);
        $display("checked %0d scores, %0d register writes, %0d mismatches",
                 scores_checked, reg_writes, mismatches);
        if (mismatches == 0 && expected_scores.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
sv/wsds_pkg.sv
sv/wsds_item_if.sv
sv/wsds_result_if.sv
sv/wsds_cfg_if.sv
sv/wsds_div.sv
sv/wsds_mac.sv
sv/weighted_sum_decision_scoring.sv
tb/tb.sv
